// ===== hw/rtl/imu_angle_kalman_filter_defines.svh =====
// Assertion macros for the IMU angle Kalman filter checker.
// No dependencies; uses i_clk and i_rst_n of the including scope.
`ifndef IMU_ANGLE_KALMAN_FILTER_DEFINES_SVH
`define IMU_ANGLE_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication
`define IKF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ikf assertion failed");

// next-cycle implication
`define IKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ikf assertion failed");

`endif

// ===== hw/rtl/ikf_pkg.sv =====
// Package for the IMU angle Kalman filter: sizes, register reset values and addresses,
// and a 32-bit saturation function. No dependencies.
package ikf_pkg;
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam int NOISE_W  = 31;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 31'd268435;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 31'd805306;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd8053064;

    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
        if (x > 70'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -70'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction
endpackage

// ===== hw/rtl/imu_angle_kalman_filter.sv =====
// IMU angle Kalman filter top level: three axes of angle and rate-bias tracking.
// Depends on ikf_pkg.
//
// One request updates one axis and returns its new angle. A filtered request makes
// ten passes through the shared 36x33 multiplier and two gain divisions on a
// restoring divider; a gain is set to zero without division when its denominator
// is not positive. A load request, or one for an axis out of range, skips the filter.
// The input side stalls while a request is in work; a result waits in the output
// register and a new request is taken meanwhile.
module imu_angle_kalman_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ikf_pkg::AXIS_W-1:0]    i_axis,
    input  logic signed [31:0]            i_measured_angle,
    input  logic signed [31:0]            i_rate,
    input  logic [23:0]                   i_step_time,
    input  logic                          i_load_angle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ikf_pkg::AXIS_W-1:0]    o_axis_out,
    output logic signed [31:0]            o_filtered_angle,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_DSET, ST_DIV, ST_DFIN, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        SP_ANG, SP_T1, SP_AA, SP_BB,
        SU_ANG, SU_BIAS, SU_AA, SU_AB, SU_BA, SU_BB
    } t_step;

    logic [ikf_pkg::NOISE_W-1:0] r_angle_noise, r_bias_noise, r_measure_noise;

    logic signed [31:0] r_ang_mem  [ikf_pkg::NUM_AXES];
    logic signed [31:0] r_bias_mem [ikf_pkg::NUM_AXES];
    logic signed [31:0] r_aa_mem   [ikf_pkg::NUM_AXES];
    logic signed [31:0] r_ab_mem   [ikf_pkg::NUM_AXES];
    logic signed [31:0] r_ba_mem   [ikf_pkg::NUM_AXES];
    logic signed [31:0] r_bb_mem   [ikf_pkg::NUM_AXES];

    t_state r_state;
    t_step  r_step;
    logic   r_dsel, r_wr_ang, r_wr_all;
    logic   r_o_valid;
    logic [ikf_pkg::AXIS_W-1:0] r_axis, r_o_axis;
    logic signed [31:0] r_o_angle, r_res;

    logic signed [31:0] r_meas, r_rate, r_ang, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [31:0] r_t1, r_ga, r_gb, r_err, r_pa, r_pb;
    logic [23:0]        r_dt;
    logic signed [68:0] r_prod;

    logic [31:0] r_den, r_rem;
    logic [59:0] r_dvd, r_quo;
    logic [5:0]  r_cnt;
    logic        r_dneg;

    logic signed [35:0] w_ma, w_inner;
    logic signed [32:0] w_mb, w_s;
    logic signed [68:0] w_rnd;
    logic signed [35:0] w_base;
    logic               w_sub;
    logic signed [31:0] w_acc, w_num;
    logic [32:0]        w_rem_sh;
    logic [31:0]        w_mag, w_gain;
    logic               w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_axis_out       = r_o_axis;
    assign o_filtered_angle = r_o_angle;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise   <= ikf_pkg::ANGLE_NOISE_RST;
            r_bias_noise    <= ikf_pkg::BIAS_NOISE_RST;
            r_measure_noise <= ikf_pkg::MEASURE_NOISE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                ikf_pkg::REG_ANGLE_NOISE:   r_angle_noise   <= pwdata[30:0];
                ikf_pkg::REG_BIAS_NOISE:    r_bias_noise    <= pwdata[30:0];
                ikf_pkg::REG_MEASURE_NOISE: r_measure_noise <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ikf_pkg::REG_ANGLE_NOISE:   prdata = {1'b0, r_angle_noise};
            ikf_pkg::REG_BIAS_NOISE:    prdata = {1'b0, r_bias_noise};
            ikf_pkg::REG_MEASURE_NOISE: prdata = {1'b0, r_measure_noise};
            default:                    prdata = '0;
        endcase
    end

    assign w_inner = 36'(r_t1) - 36'(r_ab) - 36'(r_ba) + $signed({5'b0, r_angle_noise});

    always_comb begin
        w_ma = '0;
        w_mb = $signed({9'b0, r_dt});
        unique case (r_step)
            SP_ANG:  w_ma = 36'($signed({r_rate[31], r_rate}) - $signed({r_bias[31], r_bias}));
            SP_T1:   w_ma = 36'(r_bb);
            SP_AA:   w_ma = w_inner;
            SP_BB:   w_ma = $signed({5'b0, r_bias_noise});
            SU_ANG:  begin w_ma = 36'(r_err); w_mb = 33'(r_ga); end
            SU_BIAS: begin w_ma = 36'(r_err); w_mb = 33'(r_gb); end
            SU_AA:   begin w_ma = 36'(r_pa);  w_mb = 33'(r_ga); end
            SU_AB:   begin w_ma = 36'(r_pb);  w_mb = 33'(r_ga); end
            SU_BA:   begin w_ma = 36'(r_pa);  w_mb = 33'(r_gb); end
            SU_BB:   begin w_ma = 36'(r_pb);  w_mb = 33'(r_gb); end
            default: ;
        endcase
    end

    always_comb begin
        if (r_step < SU_ANG)
            w_rnd = (r_prod + 69'sh800000) >>> 24;
        else
            w_rnd = (r_prod + 69'sh8000000) >>> 28;
        w_sub  = 1'b0;
        w_base = 36'(r_ang);
        unique case (r_step)
            SP_ANG, SU_ANG: w_base = 36'(r_ang);
            SP_T1:          w_base = '0;
            SP_AA:          w_base = 36'(r_aa);
            SP_BB:          w_base = 36'(r_bb);
            SU_BIAS:        w_base = 36'(r_bias);
            SU_AA:          begin w_base = 36'(r_pa); w_sub = 1'b1; end
            SU_AB:          begin w_base = 36'(r_pb); w_sub = 1'b1; end
            SU_BA:          begin w_base = 36'(r_ba); w_sub = 1'b1; end
            SU_BB:          begin w_base = 36'(r_bb); w_sub = 1'b1; end
            default: ;
        endcase
        if (w_sub)
            w_acc = ikf_pkg::sat32(70'(w_base) - 70'(w_rnd));
        else
            w_acc = ikf_pkg::sat32(70'(w_base) + 70'(w_rnd));
    end

    assign w_s      = $signed({r_aa[31], r_aa}) + $signed({2'b0, r_measure_noise});
    assign w_num    = r_dsel ? r_ba : r_aa;
    assign w_mag    = w_num[31] ? 32'(-w_num) : 32'(w_num);
    assign w_rem_sh = {r_rem, r_dvd[59]};

    always_comb begin
        if (r_dneg) begin
            if ((|r_quo[59:32]) || (r_quo[31] && (|r_quo[30:0])))
                w_gain = 32'h80000000;
            else
                w_gain = -r_quo[31:0];
        end else begin
            if (|r_quo[59:31])
                w_gain = 32'h7fffffff;
            else
                w_gain = r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= SP_ANG;
            r_dsel    <= 1'b0;
            r_wr_ang  <= 1'b0;
            r_wr_all  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < ikf_pkg::NUM_AXES; i++) begin
                r_ang_mem[i]  <= '0;
                r_bias_mem[i] <= '0;
                r_aa_mem[i]   <= '0;
                r_ab_mem[i]   <= '0;
                r_ba_mem[i]   <= '0;
                r_bb_mem[i]   <= '0;
            end
        end else begin
            if (r_o_valid && !i_out_stall && (r_state != ST_DONE))
                r_o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_axis   <= i_axis;
                        r_meas   <= i_measured_angle;
                        r_rate   <= i_rate;
                        r_dt     <= i_step_time;
                        r_wr_ang <= 1'b0;
                        r_wr_all <= 1'b0;
                        if (32'(i_axis) >= ikf_pkg::NUM_AXES) begin
                            r_res   <= '0;
                            r_state <= ST_DONE;
                        end else if (i_load_angle) begin
                            r_res    <= i_measured_angle;
                            r_ang    <= i_measured_angle;
                            r_wr_ang <= 1'b1;
                            r_state  <= ST_DONE;
                        end else begin
                            r_ang   <= r_ang_mem[i_axis];
                            r_bias  <= r_bias_mem[i_axis];
                            r_aa    <= r_aa_mem[i_axis];
                            r_ab    <= r_ab_mem[i_axis];
                            r_ba    <= r_ba_mem[i_axis];
                            r_bb    <= r_bb_mem[i_axis];
                            r_step  <= SP_ANG;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_ma * w_mb;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    unique case (r_step)
                        SP_ANG, SU_ANG: r_ang <= w_acc;
                        SP_T1:          r_t1  <= w_acc;
                        SP_AA: begin
                            r_aa <= w_acc;
                            r_ab <= ikf_pkg::sat32(70'(r_ab) - 70'(r_t1));
                            r_ba <= ikf_pkg::sat32(70'(r_ba) - 70'(r_t1));
                        end
                        SP_BB, SU_BB:   r_bb   <= w_acc;
                        SU_BIAS:        r_bias <= w_acc;
                        SU_AA:          r_aa   <= w_acc;
                        SU_AB:          r_ab   <= w_acc;
                        SU_BA:          r_ba   <= w_acc;
                        default: ;
                    endcase
                    if (r_step == SP_BB) begin
                        r_err   <= ikf_pkg::sat32(70'(r_meas) - 70'(r_ang));
                        r_pa    <= r_aa;
                        r_pb    <= r_ab;
                        r_dsel  <= 1'b0;
                        r_state <= ST_DSET;
                    end else if (r_step == SU_BB) begin
                        r_res    <= r_ang;
                        r_wr_all <= 1'b1;
                        r_state  <= ST_DONE;
                    end else begin
                        r_step  <= t_step'(r_step + 4'd1);
                        r_state <= ST_MUL;
                    end
                end
                ST_DSET: begin
                    if (w_s[32] || (w_s == '0)) begin
                        if (r_dsel) begin
                            r_gb    <= '0;
                            r_step  <= SU_ANG;
                            r_state <= ST_MUL;
                        end else begin
                            r_ga   <= '0;
                            r_dsel <= 1'b1;
                        end
                    end else begin
                        r_den   <= w_s[31:0];
                        r_dvd   <= {w_mag, 28'b0};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 6'd59;
                        r_dneg  <= w_num[31];
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_dvd <= {r_dvd[58:0], 1'b0};
                    if (w_rem_sh >= {1'b0, r_den}) begin
                        r_rem <= 32'(w_rem_sh - {1'b0, r_den});
                        r_quo <= {r_quo[58:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[31:0];
                        r_quo <= {r_quo[58:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0)
                        r_state <= ST_DFIN;
                end
                ST_DFIN: begin
                    if (r_dsel) begin
                        r_gb    <= w_gain;
                        r_step  <= SU_ANG;
                        r_state <= ST_MUL;
                    end else begin
                        r_ga    <= w_gain;
                        r_dsel  <= 1'b1;
                        r_state <= ST_DSET;
                    end
                end
                ST_DONE: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_axis  <= r_axis;
                        r_o_angle <= r_res;
                        if (r_wr_ang || r_wr_all)
                            r_ang_mem[r_axis] <= r_ang;
                        if (r_wr_all) begin
                            r_bias_mem[r_axis] <= r_bias;
                            r_aa_mem[r_axis]   <= r_aa;
                            r_ab_mem[r_axis]   <= r_ab;
                            r_ba_mem[r_axis]   <= r_ba;
                            r_bb_mem[r_axis]   <= r_bb;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ikf_checker.sv =====
// Port-level checker for the IMU angle Kalman filter, bound to the top level.
// Depends on ikf_pkg and imu_angle_kalman_filter_defines.svh.
`include "imu_angle_kalman_filter_defines.svh"

module ikf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [ikf_pkg::AXIS_W-1:0] o_axis_out,
    input logic signed [31:0]         o_filtered_angle
);

    `IKF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_filtered_angle) && $stable(o_axis_out))
    `IKF_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall)
    `IKF_ASSERT_NEXT(a_no_spurious, !o_out_valid && !o_in_stall, !o_out_valid)
    `IKF_ASSERT_NOW(a_bad_axis_zero, o_out_valid && (32'(o_axis_out) >= ikf_pkg::NUM_AXES), o_filtered_angle == '0)

endmodule

bind imu_angle_kalman_filter ikf_checker u_ikf_checker (.*);
